// ----- hw/rtl/cils_pkg.sv -----
// Shared types, codes and helper functions of the C integer literal scanner.
`timescale 1ns / 1ps

package cils_pkg;

    localparam int LLONG_BITS = 64;
    localparam int VALUE_W    = 64;
    localparam int WIDTH_W    = 7;

    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    localparam logic [1:0] SIZE_INT   = 2'd0;
    localparam logic [1:0] SIZE_LONG  = 2'd1;
    localparam logic [1:0] SIZE_LLONG = 2'd2;

    localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 7'd8;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 7'd64;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd32;
    localparam logic [WIDTH_W-1:0] LLONG_WIDTH = WIDTH_W'(LLONG_BITS);

    localparam int OUT_W = 72;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic [1:0]         radix;
        logic               has_digits;
        logic               digit_invalid;
        logic               overflowed;
        logic               unsigned_seen;
        logic [1:0]         size_class;
        logic               suffix_bad;
    } lit_rec_t;

    localparam lit_rec_t LIT_CLEAR = '{
        acc: '0, radix: RADIX_BIN, has_digits: 1'b0, digit_invalid: 1'b0,
        overflowed: 1'b0, unsigned_seen: 1'b0, size_class: SIZE_INT,
        suffix_bad: 1'b0
    };

    function automatic logic [WIDTH_W-1:0] sat_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] r;
        r = w;
        if (w < WIDTH_MIN) begin
            r = WIDTH_MIN;
        end else if (w > WIDTH_MAX) begin
            r = WIDTH_MAX;
        end
        return r;
    endfunction

    // Mask of the bits at or above position w; empty when w reaches the value width.
    function automatic logic [VALUE_W-1:0] high_mask(input logic [WIDTH_W-1:0] w);
        logic [VALUE_W-1:0] m;
        m = '0;
        if (w < WIDTH_W'(VALUE_W)) begin
            m = {VALUE_W{1'b1}} << w[5:0];
        end
        return m;
    endfunction

endpackage

// ----- hw/rtl/cils_front.sv -----
// Front scanner: accepts characters, accumulates digits and suffixes, pushes finished literals.
`timescale 1ns / 1ps

module cils_front import cils_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_accept,
    input  logic [7:0] char_code,
    input  logic       end_of_input,
    output logic       rec_push,
    output lit_rec_t   rec_data
);

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_ZERO     = 3'd1;
    localparam logic [2:0] PH_DIGITS   = 3'd2;
    localparam logic [2:0] PH_AFTER_U  = 3'd3;
    localparam logic [2:0] PH_AFTER_L  = 3'd4;
    localparam logic [2:0] PH_AFTER_LL = 3'd5;
    localparam logic [2:0] PH_AFTER_UL = 3'd6;
    localparam logic [2:0] PH_DONE     = 3'd7;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_L_UP  = 8'h4c;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_Z     = 8'h7a;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CASE_BIT = 8'h20;

    logic [2:0] phase_reg, phase_next;
    lit_rec_t   lit_reg, lit_next;
    logic       flu_reg, flu_next;

    logic [7:0] lower;
    logic       is_num, is_hex_alpha, is_digit, is_word, is_l, is_u, same_l;
    logic [3:0] dval;

    assign lower        = char_code | CASE_BIT;
    assign is_num       = (char_code >= CH_0) && (char_code <= CH_9);
    assign is_hex_alpha = (lower >= CH_A) && (lower <= CH_F);
    assign is_digit     = is_num || is_hex_alpha;
    assign dval         = is_num ? char_code[3:0] : 4'(lower[3:0] + 4'd9);
    assign is_word      = (char_code == CH_UNDER) || ((lower >= CH_A) && (lower <= CH_Z));
    assign is_l         = (lower == CH_L);
    assign is_u         = (lower == CH_U);
    assign same_l       = (char_code == (flu_reg ? CH_L_UP : CH_L));

    always_comb begin
        lit_rec_t    cur;
        logic [2:0]  cph;
        logic        stop;
        logic        taken;
        logic [67:0] prod;
        logic [67:0] sum;
        logic        dig_bad;

        cur        = lit_reg;
        cph        = phase_reg;
        stop       = 1'b0;
        taken      = 1'b0;
        flu_next   = flu_reg;
        rec_push   = 1'b0;
        rec_data   = lit_reg;
        prod       = '0;
        sum        = '0;
        dig_bad    = 1'b0;

        if (item_accept) begin
            if (cph == PH_ZERO) begin
                if (!end_of_input && (lower == CH_X)) begin
                    cur.radix = RADIX_HEX;
                    cph       = PH_DIGITS;
                    stop      = 1'b1;
                end else if (!end_of_input && (lower == CH_B)) begin
                    cur.radix = RADIX_BIN;
                    cph       = PH_DIGITS;
                    stop      = 1'b1;
                end else begin
                    cur.radix      = RADIX_OCT;
                    cur.has_digits = 1'b1;
                    cph            = PH_DIGITS;
                end
            end

            if (!stop) begin
                if (end_of_input) begin
                    if (cph != PH_IDLE) begin
                        rec_push = 1'b1;
                        rec_data = cur;
                    end
                    cur      = LIT_CLEAR;
                    flu_next = 1'b0;
                    cph      = PH_IDLE;
                end else begin
                    if (cph != PH_IDLE) begin
                        unique case (cur.radix)
                            RADIX_BIN: prod = {3'b000, cur.acc, 1'b0};
                            RADIX_OCT: prod = {1'b0, cur.acc, 3'b000};
                            RADIX_DEC: prod = {1'b0, cur.acc, 3'b000}
                                            + {3'b000, cur.acc, 1'b0};
                            RADIX_HEX: prod = {cur.acc, 4'b0000};
                            default:   prod = '0;
                        endcase
                        sum = prod + {64'd0, dval};
                        unique case (cur.radix)
                            RADIX_BIN: dig_bad = (dval >= 4'd2);
                            RADIX_OCT: dig_bad = (dval >= 4'd8);
                            RADIX_DEC: dig_bad = (dval >= 4'd10);
                            RADIX_HEX: dig_bad = 1'b0;
                            default:   dig_bad = 1'b0;
                        endcase

                        unique case (cph)
                            PH_DIGITS: begin
                                if (is_digit) begin
                                    cur.digit_invalid = cur.digit_invalid | dig_bad;
                                    cur.overflowed    = cur.overflowed | (|sum[67:64]);
                                    cur.acc           = sum[63:0];
                                    cur.has_digits    = 1'b1;
                                    taken             = 1'b1;
                                end else if (is_u) begin
                                    cur.unsigned_seen = 1'b1;
                                    cph               = PH_AFTER_U;
                                    taken             = 1'b1;
                                end else if (is_l) begin
                                    flu_next       = (char_code == CH_L_UP);
                                    cur.size_class = SIZE_LONG;
                                    cph            = PH_AFTER_L;
                                    taken          = 1'b1;
                                end
                            end
                            PH_AFTER_U: begin
                                if (is_l) begin
                                    flu_next       = (char_code == CH_L_UP);
                                    cur.size_class = SIZE_LONG;
                                    cph            = PH_AFTER_UL;
                                    taken          = 1'b1;
                                end
                            end
                            PH_AFTER_L: begin
                                if (same_l) begin
                                    cur.size_class = SIZE_LLONG;
                                    cph            = PH_AFTER_LL;
                                    taken          = 1'b1;
                                end else if (is_u) begin
                                    cur.unsigned_seen = 1'b1;
                                    cph               = PH_DONE;
                                    taken             = 1'b1;
                                end else if (is_word) begin
                                    cur.size_class = SIZE_INT;
                                end
                            end
                            PH_AFTER_LL: begin
                                if (is_u) begin
                                    cur.unsigned_seen = 1'b1;
                                    cph               = PH_DONE;
                                    taken             = 1'b1;
                                end
                            end
                            PH_AFTER_UL: begin
                                if (same_l) begin
                                    cur.size_class = SIZE_LLONG;
                                    cph            = PH_DONE;
                                    taken          = 1'b1;
                                end else if (is_word && !is_u) begin
                                    cur.size_class = SIZE_INT;
                                end
                            end
                            default: begin
                                taken = 1'b0;
                            end
                        endcase

                        if (!taken) begin
                            if (is_word) begin
                                cur.suffix_bad = 1'b1;
                            end
                            rec_push = 1'b1;
                            rec_data = cur;
                        end
                    end

                    // A character that does not continue a literal may start the next one.
                    if ((cph == PH_IDLE) || !taken) begin
                        cur      = LIT_CLEAR;
                        flu_next = 1'b0;
                        cph      = PH_IDLE;
                        if (char_code == CH_0) begin
                            cph = PH_ZERO;
                        end else if ((char_code >= CH_1) && (char_code <= CH_9)) begin
                            cur.radix      = RADIX_DEC;
                            cur.acc        = {60'd0, char_code[3:0]};
                            cur.has_digits = 1'b1;
                            cph            = PH_DIGITS;
                        end
                    end
                end
            end
        end

        lit_next   = cur;
        phase_next = cph;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            lit_reg   <= LIT_CLEAR;
            flu_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            lit_reg   <= lit_next;
            flu_reg   <= flu_next;
        end
    end

endmodule

// ----- hw/rtl/cils_queue.sv -----
// Two-entry queue that carries finished literals from the scanner to the classifier.
`timescale 1ns / 1ps

module cils_queue import cils_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  lit_rec_t push_data,
    input  logic     pop,
    output logic     not_empty,
    output logic     full,
    output lit_rec_t head_data
);

    lit_rec_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = 2'(count_reg + 2'd1);
        end else if (!push && pop) begin
            count_next = 2'(count_reg - 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/cils_back.sv -----
// Back end: decides validity and type of a finished literal and holds the result word.
`timescale 1ns / 1ps

module cils_back import cils_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rec_ready,
    input  lit_rec_t           rec_data,
    output logic               rec_pop,
    input  logic [WIDTH_W-1:0] int_width_bits,
    input  logic [WIDTH_W-1:0] long_width_bits,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata
);

    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]   m_tdata_reg;
    logic [OUT_W-1:0]   word;
    logic [WIDTH_W-1:0] iw, lw, bits;
    logic               valid, fits_int, fits_long, uns;
    logic [1:0]         cls, cls_val;
    logic [2:0]         tcode;

    assign iw        = sat_width(int_width_bits);
    assign lw        = sat_width(long_width_bits);
    assign valid     = rec_data.has_digits && !rec_data.digit_invalid;
    assign fits_int  = ((rec_data.acc & high_mask(iw)) == '0);
    assign fits_long = ((rec_data.acc & high_mask(lw)) == '0);
    assign cls_val   = fits_int ? SIZE_INT : (fits_long ? SIZE_LONG : SIZE_LLONG);
    assign cls       = (rec_data.size_class > cls_val) ? rec_data.size_class : cls_val;

    always_comb begin
        unique case (cls)
            SIZE_INT:  bits = iw;
            SIZE_LONG: bits = lw;
            default:   bits = LLONG_WIDTH;
        endcase
    end

    assign uns   = rec_data.unsigned_seen
                 || ((rec_data.acc & high_mask(7'(bits - 7'd1))) != '0);
    assign tcode = valid ? {cls, uns} : 3'd0;

    assign word = {rec_data.suffix_bad && rec_data.has_digits,
                   valid && rec_data.overflowed,
                   rec_data.radix,
                   tcode,
                   valid ? rec_data.acc : 64'd0,
                   valid};

    assign rec_pop       = rec_ready && (!m_tvalid_reg || m_tready);
    assign m_tvalid_next = rec_pop || (m_tvalid_reg && !m_tready);
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (rec_pop) begin
            m_tdata_reg <= word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ----- hw/rtl/c_integer_literal_scanner.sv -----
// Top level of the C integer literal scanner with its register port.
`timescale 1ns / 1ps

// The scanner takes one source character a cycle while its result queue is
// not full, and recognises C integer constants in decimal, octal, hexadecimal
// and binary, with the u, l, ll and combined suffixes. A constant is reported
// by one result word when the first character that does not belong to it
// arrives, or on an end-of-input word; that character then starts the next
// scan. Its record passes through the queue into the registered result word.
// Each digit is added in by the scanner's shift-and-add accumulator, and a
// two-word queue feeding the result register lets the input run on while a
// result waits to be taken. The int and long widths used for type selection
// live at byte addresses 0 and 4, reset to 32, and are clamped to 8..64 where
// used (a read returns the raw value); they are to be written only while no literal is in flight.
module c_integer_literal_scanner import cils_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // char_code
    input  logic         s_tlast,   // end_of_input
    output logic         m_tvalid,
    input  logic         m_tready,
    // is_valid[0], literal_value[64:1], type_code[67:65], radix_code[69:68],
    // was_truncated[70], suffix_error[71]
    output logic [71:0]  m_tdata
);

    logic [WIDTH_W-1:0] int_w_reg, int_w_next;
    logic [WIDTH_W-1:0] long_w_reg, long_w_next;
    logic               cfg_write;
    logic               item_accept;
    logic               rec_push, rec_pop, q_not_empty, q_full;
    lit_rec_t           rec_in, rec_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = {25'd0, paddr[2] ? long_w_reg : int_w_reg};

    always_comb begin
        int_w_next  = int_w_reg;
        long_w_next = long_w_reg;
        if (cfg_write) begin
            if (paddr[2]) begin
                long_w_next = pwdata[WIDTH_W-1:0];
            end else begin
                int_w_next = pwdata[WIDTH_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_w_reg  <= WIDTH_RESET;
            long_w_reg <= WIDTH_RESET;
        end else begin
            int_w_reg  <= int_w_next;
            long_w_reg <= long_w_next;
        end
    end

    assign s_tready    = !q_full;
    assign item_accept = s_tvalid && s_tready;

    cils_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_accept  (item_accept),
        .char_code    (s_tdata),
        .end_of_input (s_tlast),
        .rec_push     (rec_push),
        .rec_data     (rec_in)
    );

    cils_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data (rec_in),
        .pop       (rec_pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head_data (rec_head)
    );

    cils_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .rec_ready       (q_not_empty),
        .rec_data        (rec_head),
        .rec_pop         (rec_pop),
        .int_width_bits  (int_w_reg),
        .long_width_bits (long_w_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

endmodule
